>>> hw/rtl/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg: shared types and constants for the button debouncer
// button count, queue geometry, transaction structs and the queue control
// bundle that the lanes and the event queue share
// ----------------------------------------------------------------------------
package mbd_pkg;

  localparam int BUTTON_COUNT = 5;
  localparam int QUEUE_DEPTH  = 8;

  localparam int CODE_W = $clog2(BUTTON_COUNT + 1);
  localparam int PTR_W  = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = $clog2(QUEUE_DEPTH + BUTTON_COUNT + 1);
  localparam int TIME_W = 32;
  localparam int DEB_W  = 16;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(50);

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_POP    = 2'd1,
    MODE_RESYNC = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic [BUTTON_COUNT-1:0] raw_levels;
    logic [TIME_W-1:0]       now_ms;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]       event_button;
    logic [BUTTON_COUNT-1:0] stable_pressed;
    logic [CNT_W-1:0]        queue_count;
  } out_item_t;

  // one accepted transaction's effect on the queue
  typedef struct packed {
    logic [BUTTON_COUNT-1:0] push_mask;
    logic                    pop;
    logic                    clear;
  } queue_ctrl_t;

endpackage

>>> hw/rtl/mbd_lane.sv
// ----------------------------------------------------------------------------
// mbd_lane: debounce state of one button
// candidate level, candidate start time and stable level; flags a new press
// ----------------------------------------------------------------------------
module mbd_lane (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           sample_i,
  input  logic                           resync_i,
  input  logic                           pressed_i,
  input  logic [mbd_pkg::TIME_W-1:0]     now_i,
  input  logic [mbd_pkg::DEB_W-1:0]      debounce_i,
  output logic                           stable_nxt_o,
  output logic                           press_o
);

  logic                        cand_r, cand_nxt;
  logic                        stable_r, stable_nxt;
  logic [mbd_pkg::TIME_W-1:0]  since_r, since_nxt;
  logic [mbd_pkg::TIME_W-1:0]  elapsed;

  assign elapsed = now_i - since_r;

  always_comb begin
    cand_nxt   = cand_r;
    stable_nxt = stable_r;
    since_nxt  = since_r;
    press_o    = 1'b0;
    if (resync_i) begin
      cand_nxt   = pressed_i;
      stable_nxt = pressed_i;
      since_nxt  = now_i;
    end else if (sample_i) begin
      if (pressed_i != cand_r) begin
        // level moved: restart the candidate timer
        cand_nxt  = pressed_i;
        since_nxt = now_i;
      end else if (pressed_i != stable_r &&
                   elapsed >= mbd_pkg::TIME_W'(debounce_i)) begin
        stable_nxt = pressed_i;
        press_o    = pressed_i;
      end
    end
  end

  assign stable_nxt_o = stable_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r   <= 1'b0;
      stable_r <= 1'b0;
      since_r  <= '0;
    end else begin
      cand_r   <= cand_nxt;
      stable_r <= stable_nxt;
      since_r  <= since_nxt;
    end
  end

endmodule

>>> hw/rtl/mbd_event_queue.sv
// ----------------------------------------------------------------------------
// mbd_event_queue: merges lane presses into the event fifo
// presses are slotted in button order, overflow is dropped, pops take the
// oldest code
// ----------------------------------------------------------------------------
module mbd_event_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mbd_pkg::queue_ctrl_t         ctrl_i,
  output logic [mbd_pkg::CODE_W-1:0]   pop_code_o,
  output logic [mbd_pkg::CNT_W-1:0]    count_nxt_o
);

  localparam int BC = mbd_pkg::BUTTON_COUNT;
  localparam int QD = mbd_pkg::QUEUE_DEPTH;
  localparam int SW = mbd_pkg::SUM_W;

  logic [mbd_pkg::CODE_W-1:0] store_r [QD];
  logic [mbd_pkg::PTR_W-1:0]  rp_r, rp_nxt;
  logic [mbd_pkg::PTR_W-1:0]  wp_r, wp_nxt;
  logic [mbd_pkg::CNT_W-1:0]  count_r, count_nxt;

  logic [SW-1:0]              offs [BC];
  logic [BC-1:0]              wr_en;
  logic [mbd_pkg::PTR_W-1:0]  wr_addr [BC];
  logic [SW-1:0]              total;
  logic [SW-1:0]              written;
  logic [SW-1:0]              wsum;

  // slot of each press = presses of lower-numbered buttons
  always_comb begin
    for (int i = 0; i < BC; i++) begin
      offs[i] = '0;
      for (int k = 0; k < i; k++) begin
        offs[i] = offs[i] + SW'(ctrl_i.push_mask[k]);
      end
      wr_en[i] = ctrl_i.push_mask[i] && ((SW'(count_r) + offs[i]) < SW'(QD));
      wsum     = SW'(wp_r) + offs[i];
      if (wsum >= SW'(QD)) begin
        wsum = wsum - SW'(QD);
      end
      wr_addr[i] = wsum[mbd_pkg::PTR_W-1:0];
    end
  end

  always_comb begin
    total = SW'(count_r);
    for (int i = 0; i < BC; i++) begin
      total = total + SW'(ctrl_i.push_mask[i]);
    end
    if (total > SW'(QD)) begin
      total = SW'(QD);
    end
    written = total - SW'(count_r);

    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    count_nxt  = count_r;
    pop_code_o = '0;
    if (ctrl_i.clear) begin
      rp_nxt    = '0;
      wp_nxt    = '0;
      count_nxt = '0;
    end else if (ctrl_i.pop) begin
      if (count_r != '0) begin
        pop_code_o = store_r[rp_r];
        rp_nxt     = (rp_r == mbd_pkg::PTR_W'(QD - 1)) ? '0 : rp_r + 1'b1;
        count_nxt  = count_r - 1'b1;
      end
    end else begin
      count_nxt = total[mbd_pkg::CNT_W-1:0];
      if (SW'(wp_r) + written >= SW'(QD)) begin
        wp_nxt = mbd_pkg::PTR_W'(SW'(wp_r) + written - SW'(QD));
      end else begin
        wp_nxt = mbd_pkg::PTR_W'(SW'(wp_r) + written);
      end
    end
  end

  assign count_nxt_o = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r    <= '0;
      wp_r    <= '0;
      count_r <= '0;
    end else begin
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BC; i++) begin
      if (wr_en[i]) begin
        store_r[wr_addr[i]] <= mbd_pkg::CODE_W'(i + 1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= mbd_pkg::CNT_W'(QD))
    else $error("event count above queue depth");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!ctrl_i.pop && !ctrl_i.clear && ctrl_i.push_mask == '0)
      |=> ($stable(count_r) && $stable(rp_r) && $stable(wp_r)))
    else $error("queue moved without a transaction");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_i.clear |=> (count_r == '0 && rp_r == wp_r))
    else $error("resync left events in the queue");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_i.pop && count_r == '0) |-> (pop_code_o == '0 && count_nxt == '0))
    else $error("pop from empty queue returned a code");

endmodule

>>> hw/rtl/multi_button_debounce_event_fifo.sv
// ----------------------------------------------------------------------------
// multi_button_debounce_event_fifo: debouncer for active-low buttons with a
// press event queue
// result: each accepted input transaction's result is registered in the output register
// throughput: one transaction per cycle while in_ready is high (output register
//   empty or being read); lanes and queue pointers update on each accepted one
// reset: synchronous active low; lanes and queue empty, debounce_ms = 50
// ----------------------------------------------------------------------------
module multi_button_debounce_event_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_we,
  input  logic [mbd_pkg::DEB_W-1:0]  cfg_wdata,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mbd_pkg::in_item_t          in_data,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output mbd_pkg::out_item_t         out_data
);

  localparam int BC = mbd_pkg::BUTTON_COUNT;

  logic [mbd_pkg::DEB_W-1:0]  debounce_r;
  logic                       out_valid_r, out_valid_nxt;
  mbd_pkg::out_item_t         out_data_r, out_data_nxt;

  logic                       accept;
  mbd_pkg::mode_t             mode;
  logic                       sample, pop, resync;
  logic [BC-1:0]              pressed;
  logic [BC-1:0]              stable_nxt;
  logic [BC-1:0]              press;
  mbd_pkg::queue_ctrl_t       qctrl;
  logic [mbd_pkg::CODE_W-1:0] pop_code;
  logic [mbd_pkg::CNT_W-1:0]  count_nxt;

  // the output register takes a new result when it is empty or the old one leaves
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // pins are active low
  assign pressed = ~in_data.raw_levels;
  assign mode    = mbd_pkg::mode_t'(in_data.mode);

  // decode the mode; the unused code does nothing
  always_comb begin
    sample = 1'b0;
    pop    = 1'b0;
    resync = 1'b0;
    unique case (mode)
      mbd_pkg::MODE_SAMPLE: sample = accept;
      mbd_pkg::MODE_POP:    pop    = accept;
      mbd_pkg::MODE_RESYNC: resync = accept;
      default: ;
    endcase
  end

  // one debounce lane per button, all updated in the same cycle
  for (genvar g = 0; g < BC; g++) begin : g_lane
    mbd_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .sample_i     (sample),
      .resync_i     (resync),
      .pressed_i    (pressed[g]),
      .now_i        (in_data.now_ms),
      .debounce_i   (debounce_r),
      .stable_nxt_o (stable_nxt[g]),
      .press_o      (press[g])
    );
  end

  // merge: new presses go into the queue in button order
  assign qctrl.push_mask = press;
  assign qctrl.pop       = pop;
  assign qctrl.clear     = resync;

  mbd_event_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl_i      (qctrl),
    .pop_code_o  (pop_code),
    .count_nxt_o (count_nxt)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.event_button   = pop_code;
      out_data_nxt.stable_pressed = stable_nxt;
      out_data_nxt.queue_count    = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      debounce_r  <= mbd_pkg::DEBOUNCE_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        debounce_r <= cfg_wdata;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
